[rtl/mcuart_pkg.sv]
`default_nettype none

package mcuart_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SEND  = 2'd1,
    OP_READ  = 2'd2,
    OP_FLUSH = 2'd3
  } uart_op_t;

  localparam int unsigned FRAME_BITS    = 10;
  localparam int unsigned DATA_BITS     = 8;
  localparam int unsigned TICKS_PER_BIT = 3;
  localparam int unsigned FIRST_SAMPLE  = 4;
  localparam int unsigned PIN_BITS      = 4;

  localparam logic [1:0] TX_CNT_RELOAD  = 2'(TICKS_PER_BIT);
  localparam logic [3:0] TX_BITS_LOAD   = 4'(FRAME_BITS);
  localparam logic [2:0] RX_CNT_RELOAD  = 3'(TICKS_PER_BIT);
  localparam logic [2:0] RX_CNT_FIRST   = 3'(FIRST_SAMPLE);
  localparam logic [3:0] RX_BITS_LOAD   = 4'(DATA_BITS);

endpackage

`default_nettype wire

[rtl/multichannel_uart_3x_oversampled_top.sv]
// Multichannel 8N1 UART with a shared 3x baud tick and a receive FIFO per channel.
// Input channel: one request per accepted item (in_valid high, in_stall low).
// The operation is a baud tick (all transmitters and enabled receivers advance,
// rx pins sampled), a send of in_tx_byte, a read of one FIFO byte, or a FIFO flush.
// Every request yields exactly one result on the output channel: the transmit
// pin levels, read byte and valid flag, send acceptance, and per-channel
// FIFO-not-empty and transmitter-busy flags, all taken after the request.
// out_valid rises when the output register loads the result: the request and its
// registered FIFO read first fill the read stage, then the output register loads.
// Throughput is one request per cycle; in_stall rises only while both the
// memory stage and the output register hold results and out_stall is high.
// The per-channel FIFO store is a memory of FIFO_DEPTH bytes with one write
// and one registered read port; its contents are not cleared by reset.
// Reset (rst_n low at a clock edge) idles all lines high, clears the frame
// counters and FIFO pointers, enables all receivers, and empties the pipeline.
// cfg_wr_en writes the receiver enable mask; write it only while idle.
`default_nettype none

module multichannel_uart_3x_oversampled_top #(
  parameter int unsigned CHANNELS   = 4,
  parameter int unsigned FIFO_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       cfg_wr_en,
  input  wire logic [3:0] cfg_wr_data,

  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [1:0] in_channel,
  input  wire logic [7:0] in_tx_byte,
  input  wire logic [3:0] in_rx_pins,

  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_tx_pins,
  output logic [7:0]      out_read_byte,
  output logic            out_read_valid,
  output logic            out_send_accepted,
  output logic [3:0]      out_rx_available,
  output logic [3:0]      out_tx_busy
);

  import mcuart_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  // Configuration.
  logic [3:0] rx_mask_r;

  // Per-channel control state, one lane per channel.
  logic [CHANNELS-1:0] tx_line_r,   tx_line_nxt;
  logic [CHANNELS-1:0] tx_active_r, tx_active_nxt;
  logic [1:0]          tx_cnt_r     [CHANNELS];
  logic [1:0]          tx_cnt_nxt   [CHANNELS];
  logic [3:0]          tx_bits_r    [CHANNELS];
  logic [3:0]          tx_bits_nxt  [CHANNELS];
  logic [9:0]          tx_shift_r   [CHANNELS];
  logic [9:0]          tx_shift_nxt [CHANNELS];
  logic [CHANNELS-1:0] rx_active_r, rx_active_nxt;
  logic [CHANNELS-1:0] rx_await_r,  rx_await_nxt;
  logic [2:0]          rx_cnt_r     [CHANNELS];
  logic [2:0]          rx_cnt_nxt   [CHANNELS];
  logic [3:0]          rx_bits_r    [CHANNELS];
  logic [3:0]          rx_bits_nxt  [CHANNELS];
  logic [7:0]          rx_shift_r   [CHANNELS];
  logic [7:0]          rx_shift_nxt [CHANNELS];
  logic [7:0]          rx_bmask_r   [CHANNELS];
  logic [7:0]          rx_bmask_nxt [CHANNELS];
  logic [PTR_W-1:0]    wp_r         [CHANNELS];
  logic [PTR_W-1:0]    wp_nxt       [CHANNELS];
  logic [PTR_W-1:0]    rp_r         [CHANNELS];
  logic [PTR_W-1:0]    rp_nxt       [CHANNELS];

  logic [CHANNELS-1:0] rx_en;
  logic [CHANNELS-1:0] rx_pin;
  logic [CHANNELS-1:0] fifo_we;
  logic [7:0]          rd_data_r [CHANNELS];

  logic       in_acc;
  uart_op_t   op;
  logic       send_acc;
  logic       read_hit;
  logic [3:0] txp_nxt, avail_nxt, busy_nxt;

  // Memory read stage.
  logic       s1_valid_r;
  logic [1:0] s1_ch_r;
  logic       s1_rvalid_r;
  logic       s1_acc_r;
  logic [3:0] s1_txp_r, s1_avail_r, s1_busy_r;
  logic       out_load;
  logic [7:0] rd_sel;

  assign op       = uart_op_t'(in_operation);
  assign out_load = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  // Channels beyond the mask width are always enabled and see an idle line.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane_in
    if (c < PIN_BITS) begin : g_pin
      assign rx_en[c]  = rx_mask_r[c];
      assign rx_pin[c] = in_rx_pins[c];
    end else begin : g_nopin
      assign rx_en[c]  = 1'b1;
      assign rx_pin[c] = 1'b1;
    end
  end

  always_comb begin
    logic [1:0] tcnt;
    logic [2:0] rcnt;
    logic [3:0] tbits;
    logic [3:0] rbits;
    tx_line_nxt   = tx_line_r;
    tx_active_nxt = tx_active_r;
    rx_active_nxt = rx_active_r;
    rx_await_nxt  = rx_await_r;
    fifo_we       = '0;
    send_acc      = 1'b0;
    read_hit      = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      tx_cnt_nxt[c]   = tx_cnt_r[c];
      tx_bits_nxt[c]  = tx_bits_r[c];
      tx_shift_nxt[c] = tx_shift_r[c];
      rx_cnt_nxt[c]   = rx_cnt_r[c];
      rx_bits_nxt[c]  = rx_bits_r[c];
      rx_shift_nxt[c] = rx_shift_r[c];
      rx_bmask_nxt[c] = rx_bmask_r[c];
      wp_nxt[c]       = wp_r[c];
      rp_nxt[c]       = rp_r[c];
      tcnt            = tx_cnt_r[c] - 2'd1;
      rcnt            = rx_cnt_r[c] - 3'd1;
      tbits           = tx_bits_r[c] - 4'd1;
      rbits           = rx_bits_r[c] - 4'd1;

      if (in_acc && op == OP_TICK) begin
        if (tx_active_r[c]) begin
          if (tcnt == 2'd0) begin
            tx_line_nxt[c]  = tx_shift_r[c][0];
            tx_shift_nxt[c] = {1'b0, tx_shift_r[c][9:1]};
            tcnt            = TX_CNT_RELOAD;
            tx_bits_nxt[c]  = tbits;
            if (tbits == 4'd0) begin
              tx_active_nxt[c] = 1'b0;
            end
          end
          tx_cnt_nxt[c] = tcnt;
        end
        if (rx_en[c]) begin
          priority if (rx_await_r[c]) begin
            // Stop bit period: the byte is committed when it runs out.
            rx_cnt_nxt[c] = rcnt;
            if (rcnt == 3'd0) begin
              rx_await_nxt[c]  = 1'b0;
              rx_active_nxt[c] = 1'b0;
              fifo_we[c]       = 1'b1;
              wp_nxt[c]        = (wp_r[c] == PTR_LAST) ? '0 : wp_r[c] + 1'b1;
            end
          end else if (!rx_active_r[c]) begin
            if (!rx_pin[c]) begin
              rx_active_nxt[c] = 1'b1;
              rx_shift_nxt[c]  = '0;
              rx_cnt_nxt[c]    = RX_CNT_FIRST;
              rx_bits_nxt[c]   = RX_BITS_LOAD;
              rx_bmask_nxt[c]  = 8'd1;
            end
          end else begin
            if (rcnt == 3'd0) begin
              rcnt = RX_CNT_RELOAD;
              if (rx_pin[c]) begin
                rx_shift_nxt[c] = rx_shift_r[c] | rx_bmask_r[c];
              end
              rx_bmask_nxt[c] = {rx_bmask_r[c][6:0], 1'b0};
              rx_bits_nxt[c]  = rbits;
              if (rbits == 4'd0) begin
                rx_await_nxt[c] = 1'b1;
              end
            end
            rx_cnt_nxt[c] = rcnt;
          end
        end
      end else if (in_acc && int'(in_channel) == c) begin
        unique case (op)
          OP_SEND: begin
            if (!tx_active_r[c]) begin
              tx_cnt_nxt[c]    = TX_CNT_RELOAD;
              tx_bits_nxt[c]   = TX_BITS_LOAD;
              tx_shift_nxt[c]  = {1'b1, in_tx_byte, 1'b0};
              tx_active_nxt[c] = 1'b1;
              send_acc         = 1'b1;
            end
          end
          OP_READ: begin
            if (rp_r[c] != wp_r[c]) begin
              rp_nxt[c] = (rp_r[c] == PTR_LAST) ? '0 : rp_r[c] + 1'b1;
              read_hit  = 1'b1;
            end
          end
          OP_FLUSH: begin
            wp_nxt[c] = '0;
            rp_nxt[c] = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  for (genvar c = 0; c < PIN_BITS; c++) begin : g_status
    if (c < CHANNELS) begin : g_present
      assign txp_nxt[c]   = tx_line_nxt[c];
      assign avail_nxt[c] = (wp_nxt[c] != rp_nxt[c]);
      assign busy_nxt[c]  = tx_active_nxt[c];
    end else begin : g_absent
      assign txp_nxt[c]   = 1'b0;
      assign avail_nxt[c] = 1'b0;
      assign busy_nxt[c]  = 1'b0;
    end
  end

  // FIFO store per channel. A write and a used read never land in the same cycle,
  // since only a tick writes and only a read request uses the read data.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_fifo
    logic [7:0] mem [FIFO_DEPTH];

    always_ff @(posedge clk) begin
      if (fifo_we[c]) begin
        mem[wp_r[c]] <= rx_shift_r[c];
      end
      if (in_acc) begin
        rd_data_r[c] <= mem[rp_r[c]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_mask_r   <= 4'hF;
      tx_line_r   <= '1;
      tx_active_r <= '0;
      rx_active_r <= '0;
      rx_await_r  <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        tx_cnt_r[c]   <= '0;
        tx_bits_r[c]  <= '0;
        tx_shift_r[c] <= '0;
        rx_cnt_r[c]   <= '0;
        rx_bits_r[c]  <= '0;
        rx_shift_r[c] <= '0;
        rx_bmask_r[c] <= '0;
        wp_r[c]       <= '0;
        rp_r[c]       <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        rx_mask_r <= cfg_wr_data;
      end
      tx_line_r   <= tx_line_nxt;
      tx_active_r <= tx_active_nxt;
      rx_active_r <= rx_active_nxt;
      rx_await_r  <= rx_await_nxt;
      for (int c = 0; c < CHANNELS; c++) begin
        tx_cnt_r[c]   <= tx_cnt_nxt[c];
        tx_bits_r[c]  <= tx_bits_nxt[c];
        tx_shift_r[c] <= tx_shift_nxt[c];
        rx_cnt_r[c]   <= rx_cnt_nxt[c];
        rx_bits_r[c]  <= rx_bits_nxt[c];
        rx_shift_r[c] <= rx_shift_nxt[c];
        rx_bmask_r[c] <= rx_bmask_nxt[c];
        wp_r[c]       <= wp_nxt[c];
        rp_r[c]       <= rp_nxt[c];
      end
    end
  end

  // Memory read stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r     <= in_channel;
      s1_rvalid_r <= read_hit;
      s1_acc_r    <= send_acc;
      s1_txp_r    <= txp_nxt;
      s1_avail_r  <= avail_nxt;
      s1_busy_r   <= busy_nxt;
    end
  end

  always_comb begin
    rd_sel = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(s1_ch_r) == c) begin
        rd_sel = rd_data_r[c];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tx_pins       <= s1_txp_r;
      out_read_byte     <= s1_rvalid_r ? rd_sel : 8'd0;
      out_read_valid    <= s1_rvalid_r;
      out_send_accepted <= s1_acc_r;
      out_rx_available  <= s1_avail_r;
      out_tx_busy       <= s1_busy_r;
    end
  end

  // A receiver only waits out the stop bit while it is in a frame.
  a_await_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_await_r & ~rx_active_r) == '0)
    else $error("receiver awaits stop bit outside a frame");

  // Backpressure reaches the input only when the read stage is occupied.
  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty read stage");

  // Every accepted request occupies the read stage in the next cycle.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted request lost before the read stage");

  // A send is accepted only by a transmitter that was idle.
  a_send_idle: assert property (@(posedge clk) disable iff (!rst_n)
    send_acc |-> ($countones(tx_active_nxt & ~tx_active_r) == 1))
    else $error("send accepted without starting a frame");

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mcuart_pkg::*;

  localparam int NCH         = 4;
  localparam int DEPTH       = 32;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [3:0] tx_pins;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       send_accepted;
    logic [3:0] rx_available;
    logic [3:0] tx_busy;
  } uart_status_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_wr_en    = 1'b0;
  logic [3:0] cfg_wr_data  = 4'h0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = OP_TICK;
  logic [1:0] in_channel   = 2'd0;
  logic [7:0] in_tx_byte   = 8'h00;
  logic [3:0] in_rx_pins   = 4'hF;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [3:0] out_tx_pins;
  logic [7:0] out_read_byte;
  logic       out_read_valid;
  logic       out_send_accepted;
  logic [3:0] out_rx_available;
  logic [3:0] out_tx_busy;

  multichannel_uart_3x_oversampled_top #(
    .CHANNELS   (NCH),
    .FIFO_DEPTH (DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_channel        (in_channel),
    .in_tx_byte        (in_tx_byte),
    .in_rx_pins        (in_rx_pins),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_pins       (out_tx_pins),
    .out_read_byte     (out_read_byte),
    .out_read_valid    (out_read_valid),
    .out_send_accepted (out_send_accepted),
    .out_rx_available  (out_rx_available),
    .out_tx_busy       (out_tx_busy)
  );

  // Predicted UART state, one entry per channel.
  logic [3:0] rx_mask;
  logic       tx_level   [NCH];
  logic       tx_running [NCH];
  logic [1:0] tx_ticks   [NCH];
  logic [3:0] tx_left    [NCH];
  logic [9:0] tx_frame   [NCH];
  logic       rx_running [NCH];
  logic       rx_in_stop [NCH];
  logic [2:0] rx_ticks   [NCH];
  logic [3:0] rx_left    [NCH];
  logic [7:0] rx_data    [NCH];
  logic [7:0] rx_bit     [NCH];
  logic [7:0] fifo_mem   [NCH][DEPTH];
  logic [4:0] fifo_wr    [NCH];
  logic [4:0] fifo_rd    [NCH];

  uart_status_t pending_status[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int line_noise_permille = 0;
  logic [1:0] line_route [NCH];

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multichannel_uart_3x_oversampled_top regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic void reset_uart_model();
    rx_mask = 4'hF;
    for (int c = 0; c < NCH; c++) begin
      tx_level[c]   = 1'b1;
      tx_running[c] = 1'b0;
      tx_ticks[c]   = '0;
      tx_left[c]    = '0;
      tx_frame[c]   = '0;
      rx_running[c] = 1'b0;
      rx_in_stop[c] = 1'b0;
      rx_ticks[c]   = '0;
      rx_left[c]    = '0;
      rx_data[c]    = '0;
      rx_bit[c]     = '0;
      fifo_wr[c]    = '0;
      fifo_rd[c]    = '0;
      line_route[c] = 2'(c);
      for (int i = 0; i < DEPTH; i++) fifo_mem[c][i] = '0;
    end
  endfunction

  // Applies one request to the predicted state and returns the status it produces.
  function automatic uart_status_t advance_uart(uart_op_t op, logic [1:0] chan,
                                                logic [7:0] data, logic [3:0] pins);
    uart_status_t s;
    logic [1:0]   tcnt;
    logic [2:0]   rcnt;
    s = '0;
    if (op == OP_TICK) begin
      for (int c = 0; c < NCH; c++) begin
        if (tx_running[c]) begin
          tcnt = tx_ticks[c] - 2'd1;
          if (tcnt == 2'd0) begin
            tx_level[c] = tx_frame[c][0];
            tx_frame[c] = tx_frame[c] >> 1;
            tcnt = TX_CNT_RELOAD;
            tx_left[c] = tx_left[c] - 4'd1;
            if (tx_left[c] == 4'd0) tx_running[c] = 1'b0;
          end
          tx_ticks[c] = tcnt;
        end
        if (rx_mask[c]) begin
          if (rx_in_stop[c]) begin
            // The stop bit is not sampled; the byte is stored once the wait ends.
            rx_ticks[c] = rx_ticks[c] - 3'd1;
            if (rx_ticks[c] == 3'd0) begin
              rx_in_stop[c] = 1'b0;
              rx_running[c] = 1'b0;
              fifo_mem[c][fifo_wr[c]] = rx_data[c];
              fifo_wr[c] = fifo_wr[c] + 5'd1;
            end
          end else if (!rx_running[c]) begin
            if (!pins[c]) begin
              rx_running[c] = 1'b1;
              rx_data[c]    = '0;
              rx_ticks[c]   = RX_CNT_FIRST;
              rx_left[c]    = RX_BITS_LOAD;
              rx_bit[c]     = 8'h01;
            end
          end else begin
            rcnt = rx_ticks[c] - 3'd1;
            if (rcnt == 3'd0) begin
              rcnt = RX_CNT_RELOAD;
              if (pins[c]) rx_data[c] = rx_data[c] | rx_bit[c];
              rx_bit[c]  = rx_bit[c] << 1;
              rx_left[c] = rx_left[c] - 4'd1;
              if (rx_left[c] == 4'd0) rx_in_stop[c] = 1'b1;
            end
            rx_ticks[c] = rcnt;
          end
        end
      end
    end else if (op == OP_SEND) begin
      if (!tx_running[chan]) begin
        tx_ticks[chan]   = TX_CNT_RELOAD;
        tx_left[chan]    = TX_BITS_LOAD;
        tx_frame[chan]   = {1'b1, data, 1'b0};
        tx_running[chan] = 1'b1;
        s.send_accepted  = 1'b1;
      end
    end else if (op == OP_READ) begin
      if (fifo_rd[chan] != fifo_wr[chan]) begin
        s.read_byte   = fifo_mem[chan][fifo_rd[chan]];
        s.read_valid  = 1'b1;
        fifo_rd[chan] = fifo_rd[chan] + 5'd1;
      end
    end else begin
      fifo_wr[chan] = '0;
      fifo_rd[chan] = '0;
    end
    for (int c = 0; c < NCH; c++) begin
      s.tx_pins[c]      = tx_level[c];
      s.rx_available[c] = (fifo_rd[c] != fifo_wr[c]);
      s.tx_busy[c]      = tx_running[c];
    end
    return s;
  endfunction

  // Receive levels looped back from the predicted transmit lines, with optional noise.
  function automatic logic [3:0] rx_levels();
    logic [3:0] v;
    for (int c = 0; c < NCH; c++) begin
      v[c] = tx_level[line_route[c]];
      if ($urandom_range(999) < line_noise_permille) v[c] = $urandom_range(1);
    end
    return v;
  endfunction

  // Entered and left at a falling edge; valid stays high between back-to-back requests.
  task automatic issue(input uart_op_t op, input logic [1:0] chan, input logic [7:0] data,
                       input logic [3:0] pins);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_channel   <= chan;
    in_tx_byte   <= data;
    in_rx_pins   <= pins;
    do @(posedge clk); while (in_stall);
    pending_status.push_back(advance_uart(op, chan, data, pins));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_rx_enable(input logic [3:0] mask);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mask;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    rx_mask = mask;
  endtask

  always @(posedge clk) begin : status_check
    uart_status_t got;
    uart_status_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_tx_pins, out_read_byte, out_read_valid, out_send_accepted,
             out_rx_available, out_tx_busy};
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("cycle %0d: unexpected status %h", cycle_count, got);
      end else begin
        want = pending_status.pop_front();
        if (got.tx_pins !== want.tx_pins || got.read_byte !== want.read_byte ||
            got.read_valid !== want.read_valid ||
            got.send_accepted !== want.send_accepted ||
            got.rx_available !== want.rx_available || got.tx_busy !== want.tx_busy) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"cycle %0d: expected/actual tx_pins %h/%h read %h,%b/%h,%b ",
                      "accepted %b/%b available %h/%h busy %h/%h"},
                     cycle_count, want.tx_pins, got.tx_pins, want.read_byte,
                     want.read_valid, got.read_byte, got.read_valid, want.send_accepted,
                     got.send_accepted, want.rx_available, got.rx_available,
                     want.tx_busy, got.tx_busy);
        end
      end
    end
  end

  task automatic test_basic_operations();
    sender_idle_pct = 0;
    stall_pct = 0;
    issue(OP_READ, 2'd0, 8'h00, 4'hF);
    issue(OP_READ, 2'd3, 8'hFF, 4'h0);
    issue(OP_FLUSH, 2'd1, 8'h00, 4'hF);
    issue(OP_SEND, 2'd0, 8'h00, 4'h0);
    // The channel is already busy, so this send is refused.
    issue(OP_SEND, 2'd0, 8'hFF, 4'hF);
    issue(OP_SEND, 2'd3, 8'hFF, 4'h0);
    issue(OP_SEND, 2'd1, 8'hA5, 4'h5);
    issue(OP_SEND, 2'd2, 8'h5A, 4'hA);
    repeat (3) issue(OP_TICK, 2'd3, 8'hFF, 4'hF);
    issue(OP_TICK, 2'd0, 8'h00, 4'h0);
    // Flushing mid-frame must not disturb the receiver.
    issue(OP_FLUSH, 2'd2, 8'h3C, 4'h3);
    repeat (6) issue(OP_TICK, 2'd1, 8'($urandom), rx_levels());
    issue(OP_READ, 2'd2, 8'hC3, 4'hC);
  endtask

  task automatic test_fifo_overflow();
    logic [3:0] pins;
    sender_idle_pct = 6;
    stall_pct = 6;
    // Ticks only, no reads: every receiver sees a start level as soon as it is idle,
    // so each FIFO takes more bytes than it holds and the write pointer wraps.
    for (int i = 0; i < 1000; i++) begin
      for (int c = 0; c < NCH; c++)
        pins[c] = (!rx_running[c] && !rx_in_stop[c]) ? 1'b0 : 1'($urandom_range(1));
      issue(OP_TICK, 2'($urandom), 8'($urandom), pins);
    end
    for (int c = 0; c < NCH; c++)
      while (fifo_rd[c] != fifo_wr[c]) issue(OP_READ, 2'(c), 8'($urandom), 4'($urandom));
  endtask

  task automatic test_mixed_traffic();
    logic [3:0] masks [5];
    int idle_set [5];
    int stall_set [5];
    int pick;
    masks = '{4'h0, 4'hF, 4'($urandom), 4'h9, 4'hF};
    idle_set = '{0, 72, 0, 6, 72};
    stall_set = '{0, 0, 72, 6, 72};
    for (int p = 0; p < 5; p++) begin
      write_rx_enable(masks[p]);
      sender_idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      line_noise_permille = (p == 3) ? 250 : 5;
      for (int c = 0; c < NCH; c++)
        line_route[c] = (p == 0) ? 2'(c) : 2'($urandom);
      for (int i = 0; i < 100; i++) begin
        // Hold off new requests until every outstanding status is back.
        if (i == 50) wait_drained();
        pick = $urandom_range(99);
        if (pick < 8)
          issue(OP_SEND, 2'($urandom), 8'($urandom), 4'($urandom));
        else if (pick < 20)
          issue(OP_READ, 2'($urandom), 8'($urandom), 4'($urandom));
        else if (pick < 22)
          issue(OP_FLUSH, 2'($urandom), 8'($urandom), 4'($urandom));
        else
          issue(OP_TICK, 2'($urandom), 8'($urandom), rx_levels());
      end
    end
  endtask

  initial begin
    reset_uart_model();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    test_basic_operations();
    test_fifo_overflow();
    test_mixed_traffic();
    wait_drained();
    if (mismatch_count == 0)
      $display("multichannel_uart_3x_oversampled_top regression: pass");
    else
      $display("multichannel_uart_3x_oversampled_top regression: fail");
    $finish;
  end

endmodule

[filelist.f]
rtl/mcuart_pkg.sv
rtl/multichannel_uart_3x_oversampled_top.sv
test/tb_top.sv
